FILE: rtl/ecc_pkg.sv
// Shared types, constants and shift helpers for the sensor compensation core.
// Depends on nothing; the core, ecc_mul and ecc_div import it.
`default_nettype none

package ecc_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL_TEMP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_PRESS_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_MIXED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_HUM        = 3'd4;

    localparam logic [31:0] C_HUM_FINE_OFS = 32'd76800;
    localparam logic [31:0] C_HUM_MAX      = 32'd419430400;
    localparam logic [31:0] C_HUM_RND_A    = 32'd16384;
    localparam logic [31:0] C_HUM_OFS_B    = 32'd32768;
    localparam logic [31:0] C_HUM_OFS_C    = 32'd2097152;
    localparam logic [31:0] C_HUM_RND_D    = 32'd8192;
    localparam logic [63:0] C_PRS_FINE_OFS = 64'd128000;
    localparam logic [63:0] C_PRS_BASE     = 64'd1048576;
    localparam logic [63:0] C_PRS_SCALE    = 64'd3125;
    localparam logic [63:0] C_PRS_ONE47    = 64'h0000_8000_0000_0000;

    typedef enum logic [1:0] {
        K_TEMP  = 2'd0,
        K_HUM   = 2'd1,
        K_PRESS = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    // request to a shared arithmetic unit
    typedef struct packed {
        logic        go;
        logic [63:0] a;
        logic [63:0] b;
    } t_op_req;

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [5:0] n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input logic [6:0] n);
        return 64'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sx64(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ecc_if.sv
// Valid/ready channel interfaces for the compensation core.
// Input word: kind and raw reading. Output word: the three compensated fields.
`default_nettype none

interface ecc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [19:0] raw_reading;

    modport source (output valid, kind, raw_reading, input ready);
    modport sink   (input valid, kind, raw_reading, output ready);
endinterface

interface ecc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic        [16:0] humidity_q10;
    logic        [31:0] pressure_q8;

    modport source (output valid, temperature_centi, humidity_q10, pressure_q8, input ready);
    modport sink   (input valid, temperature_centi, humidity_q10, pressure_q8, output ready);
endinterface

`default_nettype wire

FILE: rtl/env_sensor_compensation_core.sv
// Integer temperature / humidity / pressure compensation core.
// One word at a time: temperature takes 4 multiplier passes, humidity 8, and pressure
// 10 multiplier passes, a divide and a final sum; a zero pressure divisor ends the run
// before the divide, and an unused kind goes straight to hold. A pass is issue, busy, capture.
// Input ready only while idle: ready again as the result reaches the output register,
// where it may wait. Sync active-low reset clears calibration, fine temp, control.
`default_nettype none

module env_sensor_compensation_core
    import ecc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [63:0]          i_cfg_data,
    ecc_in_if.sink                    s_in,
    ecc_out_if.source                 m_out
);

    // calibration registers
    logic [47:0] r_cal_t;
    logic [63:0] r_cal_pl, r_cal_ph;
    logic [47:0] r_cal_m;
    logic [39:0] r_cal_h;

    // sequencer state
    t_state      r_state, n_state;
    t_kind       r_kind, n_kind;
    logic [3:0]  r_step, n_step;
    logic        r_wait, n_wait;
    logic [19:0] r_raw, n_raw;
    logic [31:0] r_fine, n_fine;
    logic [63:0] r_a, n_a, r_b, n_b, r_c, n_c;
    logic [31:0] r_rt, n_rt;
    logic [16:0] r_rh, n_rh;
    logic [31:0] r_rp, n_rp;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_ot, n_ot;
    logic [16:0] r_oh, n_oh;
    logic [31:0] r_op, n_op;

    // unit hookup
    t_op_req     mreq, dreq;
    logic        mul_done, div_done;
    logic [63:0] mul_p, div_q;
    logic [63:0] op_a, op_b;
    logic        use_mul, use_div;

    // decoded coefficients
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] raw32, hv, tmp32, m32, hq;
    logic [63:0] f64, pbase, psum;

    ecc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    ecc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dreq),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    always_comb begin
        t1 = {16'd0, r_cal_t[15:0]};
        t2 = {{16{r_cal_t[31]}}, r_cal_t[31:16]};
        t3 = {{16{r_cal_t[47]}}, r_cal_t[47:32]};
        p1 = {48'd0, r_cal_pl[15:0]};
        p2 = {{48{r_cal_pl[31]}}, r_cal_pl[31:16]};
        p3 = {{48{r_cal_pl[47]}}, r_cal_pl[47:32]};
        p4 = {{48{r_cal_pl[63]}}, r_cal_pl[63:48]};
        p5 = {{48{r_cal_ph[15]}}, r_cal_ph[15:0]};
        p6 = {{48{r_cal_ph[31]}}, r_cal_ph[31:16]};
        p7 = {{48{r_cal_ph[47]}}, r_cal_ph[47:32]};
        p8 = {{48{r_cal_ph[63]}}, r_cal_ph[63:48]};
        p9 = {{48{r_cal_m[15]}}, r_cal_m[15:0]};
        h1 = {24'd0, r_cal_m[23:16]};
        h2 = {{16{r_cal_m[39]}}, r_cal_m[39:24]};
        h3 = {24'd0, r_cal_m[47:40]};
        h4 = {{16{r_cal_h[15]}}, r_cal_h[15:0]};
        h5 = {{16{r_cal_h[31]}}, r_cal_h[31:16]};
        h6 = {{24{r_cal_h[39]}}, r_cal_h[39:32]};
        raw32 = {12'd0, r_raw};
        hv    = r_fine - C_HUM_FINE_OFS;
        f64   = sx64(r_fine) - C_PRS_FINE_OFS;
        pbase = C_PRS_BASE - {44'd0, r_raw};
        hq    = asr32(r_c[31:0], 6'd15);
    end

    // operand select per step; the multiplier sees every step except the divide and the final pressure sum
    always_comb begin
        op_a    = '0;
        op_b    = '0;
        use_mul = 1'b0;
        use_div = 1'b0;
        case (r_kind)
            K_TEMP: begin
                use_mul = 1'b1;
                case (r_step)
                    4'd0: begin
                        op_a = sx64((raw32 >> 3) - (t1 << 1));
                        op_b = sx64(t2);
                    end
                    4'd1: begin
                        op_a = sx64((raw32 >> 4) - t1);
                        op_b = sx64((raw32 >> 4) - t1);
                    end
                    4'd2: begin
                        op_a = r_b;
                        op_b = sx64(t3);
                    end
                    default: begin
                        op_a = sx64(r_fine);
                        op_b = 64'd5;
                    end
                endcase
            end
            K_HUM: begin
                use_mul = 1'b1;
                case (r_step)
                    4'd0: begin op_a = sx64(h5); op_b = sx64(hv); end
                    4'd1: begin op_a = sx64(hv); op_b = sx64(h6); end
                    4'd2: begin op_a = sx64(hv); op_b = sx64(h3); end
                    4'd3: begin op_a = r_b;      op_b = r_c;      end
                    4'd4: begin op_a = r_b;      op_b = sx64(h2); end
                    4'd5: begin op_a = r_a;      op_b = r_b;      end
                    4'd6: begin op_a = sx64(hq); op_b = sx64(hq); end
                    default: begin op_a = r_b;   op_b = sx64(h1); end
                endcase
            end
            K_PRESS: begin
                use_mul = 1'b1;
                case (r_step)
                    4'd0: begin op_a = f64; op_b = f64; end
                    4'd1: begin op_a = r_a; op_b = p6;  end
                    4'd2: begin op_a = f64; op_b = p5;  end
                    4'd3: begin op_a = r_a; op_b = p3;  end
                    4'd4: begin op_a = f64; op_b = p2;  end
                    4'd5: begin op_a = C_PRS_ONE47 + r_c; op_b = p1; end
                    4'd6: begin op_a = (pbase << 31) - r_b; op_b = C_PRS_SCALE; end
                    4'd7: begin
                        use_mul = 1'b0;
                        use_div = 1'b1;
                        op_a    = r_a;
                        op_b    = r_c;
                    end
                    4'd8: begin op_a = p9; op_b = asr64(r_a, 7'd13); end
                    4'd9: begin op_a = r_b; op_b = asr64(r_a, 7'd13); end
                    4'd10: begin op_a = p8; op_b = r_a; end
                    default: use_mul = 1'b0;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_step   = r_step;
        n_wait   = r_wait;
        n_raw    = r_raw;
        n_fine   = r_fine;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_rt     = r_rt;
        n_rh     = r_rh;
        n_rp     = r_rp;
        n_ovalid = r_ovalid;
        n_ot     = r_ot;
        n_oh     = r_oh;
        n_op     = r_op;
        mreq     = '{go: 1'b0, a: op_a, b: op_b};
        dreq     = '{go: 1'b0, a: op_a, b: op_b};
        m32      = mul_p[31:0];
        tmp32    = '0;
        psum     = r_a + r_b + r_c;

        if (r_ovalid && m_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_in.valid) begin
                    n_state = S_RUN;
                    n_kind  = t_kind'(s_in.kind);
                    n_raw   = s_in.raw_reading;
                    n_step  = '0;
                    n_wait  = 1'b0;
                    n_rt    = '0;
                    n_rh    = '0;
                    n_rp    = '0;
                end
            end
            S_RUN: begin
                if (use_mul || use_div) begin
                    if (!r_wait) begin
                        n_wait  = 1'b1;
                        mreq.go = use_mul;
                        dreq.go = use_div;
                    end else if (mul_done || div_done) begin
                        n_wait = 1'b0;
                        n_step = r_step + 4'd1;
                        case (r_kind)
                            K_TEMP: begin
                                case (r_step)
                                    4'd0: n_a = {32'd0, asr32(m32, 6'd11)};
                                    4'd1: n_b = sx64(asr32(m32, 6'd12));
                                    4'd2: n_fine = r_a[31:0] + asr32(m32, 6'd14);
                                    default: begin
                                        n_rt    = asr32(m32 + 32'd128, 6'd8);
                                        n_state = S_HOLD;
                                    end
                                endcase
                            end
                            K_HUM: begin
                                case (r_step)
                                    4'd0: begin
                                        tmp32 = ({12'd0, r_raw[15:0], 4'd0} << 10)
                                              - (h4 << 20) - m32 + C_HUM_RND_A;
                                        n_a = sx64(asr32(tmp32, 6'd15));
                                    end
                                    4'd1: n_b = sx64(asr32(m32, 6'd10));
                                    4'd2: n_c = sx64(asr32(m32, 6'd11) + C_HUM_OFS_B);
                                    4'd3: n_b = sx64(asr32(m32, 6'd10) + C_HUM_OFS_C);
                                    4'd4: n_b = sx64(asr32(m32 + C_HUM_RND_D, 6'd14));
                                    4'd5: n_c = sx64(m32);
                                    4'd6: n_b = sx64(asr32(m32, 6'd7));
                                    default: begin
                                        // clamp to 0..100 percent before dropping 12 bits
                                        tmp32 = r_c[31:0] - asr32(m32, 6'd4);
                                        if (tmp32[31]) begin
                                            tmp32 = '0;
                                        end else if (tmp32 > C_HUM_MAX) begin
                                            tmp32 = C_HUM_MAX;
                                        end
                                        n_rh    = tmp32[28:12];
                                        n_state = S_HOLD;
                                    end
                                endcase
                            end
                            K_PRESS: begin
                                case (r_step)
                                    4'd0: n_a = mul_p;
                                    4'd1: n_b = mul_p;
                                    4'd2: n_b = r_b + (mul_p << 17) + (p4 << 35);
                                    4'd3: n_c = asr64(mul_p, 7'd8);
                                    4'd4: n_c = r_c + (mul_p << 12);
                                    4'd5: begin
                                        n_c = asr64(mul_p, 7'd33);
                                        // zero divisor: result stays 0
                                        if (asr64(mul_p, 7'd33) == '0) begin
                                            n_state = S_HOLD;
                                        end
                                    end
                                    4'd6: n_a = mul_p;
                                    4'd7: n_a = div_q;
                                    4'd8: n_b = mul_p;
                                    4'd9: n_b = asr64(mul_p, 7'd25);
                                    default: n_c = asr64(mul_p, 7'd19);
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end else begin
                    // final pressure sum, or an unused kind with all-zero result
                    if (r_kind == K_PRESS) begin
                        n_rp = 32'(asr64(psum, 7'd8) + (p7 << 4));
                    end
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_ovalid || m_out.ready) begin
                    n_ovalid = 1'b1;
                    n_ot     = r_rt;
                    n_oh     = r_rh;
                    n_op     = r_rp;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= K_TEMP;
            r_step   <= '0;
            r_wait   <= 1'b0;
            r_fine   <= '0;
            r_ovalid <= 1'b0;
            r_cal_t  <= '0;
            r_cal_pl <= '0;
            r_cal_ph <= '0;
            r_cal_m  <= '0;
            r_cal_h  <= '0;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_step   <= n_step;
            r_wait   <= n_wait;
            r_fine   <= n_fine;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAL_TEMP:       r_cal_t  <= i_cfg_data[47:0];
                    CFG_CAL_PRESS_LOW:  r_cal_pl <= i_cfg_data;
                    CFG_CAL_PRESS_HIGH: r_cal_ph <= i_cfg_data;
                    CFG_CAL_MIXED:      r_cal_m  <= i_cfg_data[47:0];
                    CFG_CAL_HUM:        r_cal_h  <= i_cfg_data[39:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw <= n_raw;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_rt  <= n_rt;
        r_rh  <= n_rh;
        r_rp  <= n_rp;
        r_ot  <= n_ot;
        r_oh  <= n_oh;
        r_op  <= n_op;
    end

    assign s_in.ready              = (r_state == S_IDLE);
    assign m_out.valid             = r_ovalid;
    assign m_out.temperature_centi = r_ot;
    assign m_out.humidity_q10      = r_oh;
    assign m_out.pressure_q8       = r_op;

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in.valid && s_in.ready) |=> (r_state == S_RUN))
        else $error("accepted word did not start the sequencer");

    a_unit_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_done || div_done) |-> (r_wait && r_state == S_RUN))
        else $error("arithmetic unit finished with no step waiting");

    a_hold_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && (!r_ovalid || m_out.ready)) |=> m_out.valid)
        else $error("finished result not moved to output register");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mreq.go && dreq.go))
        else $error("multiplier and divider started together");

endmodule

`default_nettype wire

FILE: rtl/ecc_mul.sv
// Shared 64x64 multiplier, low 64 bits of the product, built on one 32x32 multiplier.
// Depends on ecc_pkg.
`default_nettype none

module ecc_mul
    import ecc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_op_req     i_req,
    output logic             o_done,
    output logic [63:0]      o_prod
);

    logic [63:0] r_a, r_b, r_prod, r_acc;
    logic [2:0]  r_ph;
    logic        r_busy, r_done;
    logic [31:0] sel_a, sel_b;

    // partial products: lo*lo, lo*hi, hi*lo (hi*hi falls outside 64 bits)
    always_comb begin
        sel_a = r_a[31:0];
        sel_b = r_b[31:0];
        case (r_ph)
            3'd1:    sel_b = r_b[63:32];
            3'd2:    sel_a = r_a[63:32];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go && !r_busy) begin
                r_busy <= 1'b1;
                r_ph   <= '0;
            end else if (r_busy) begin
                r_ph <= r_ph + 3'd1;
                if (r_ph == 3'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go && !r_busy) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end else if (r_busy) begin
            r_prod <= sel_a * sel_b;
            case (r_ph)
                3'd1:    r_acc <= r_prod;
                3'd2:    r_acc <= r_acc + {r_prod[31:0], 32'd0};
                3'd3:    r_acc <= r_acc + {r_prod[31:0], 32'd0};
                default: ;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

FILE: rtl/ecc_div.sv
// Signed 64-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on ecc_pkg. Divisor must be nonzero.
`default_nettype none

module ecc_div
    import ecc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_op_req     i_req,
    output logic             o_done,
    output logic [63:0]      o_quo
);

    logic [63:0] r_q, r_r, r_md;
    logic [6:0]  r_cnt;
    logic        r_neg, r_done;
    logic [64:0] sh, diff;
    logic [63:0] q_next;

    always_comb begin
        sh     = {r_r, r_q[63]};
        diff   = sh - {1'b0, r_md};
        q_next = {r_q[62:0], ~diff[64]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go && r_cnt == '0) begin
                r_cnt <= 7'd64;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go && r_cnt == '0) begin
            r_q   <= i_req.a[63] ? -i_req.a : i_req.a;
            r_md  <= i_req.b[63] ? -i_req.b : i_req.b;
            r_r   <= '0;
            r_neg <= i_req.a[63] ^ i_req.b[63];
        end else if (r_cnt != '0) begin
            r_r <= diff[64] ? sh[63:0] : diff[63:0];
            if (r_cnt == 7'd1) begin
                r_q <= r_neg ? -q_next : q_next;
            end else begin
                r_q <= q_next;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire
